/* sv/wfdc_pkg.sv */
package wfdc_pkg;

  localparam int unsigned DistW    = 10;
  localparam int unsigned MarginW  = 8;
  localparam int unsigned CompW    = 12;
  localparam int unsigned TurnW    = 11;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned HeadW    = 20;
  localparam int unsigned TargetW  = 21;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned DirW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic signed [TargetW-1:0] QuarterTurn = 21'sd1440;

  localparam logic [CfgIdxW-1:0] CfgFrontSafe = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSafe      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWallMrg   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCompAng   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTurnMrg   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgFullSpd   = 3'd5;

  localparam logic [PhaseW-1:0] PhWaitCorner = 3'd0;
  localparam logic [PhaseW-1:0] PhWaitClear  = 3'd1;
  localparam logic [PhaseW-1:0] PhFollow     = 3'd2;
  localparam logic [PhaseW-1:0] PhTurnLeft   = 3'd3;
  localparam logic [PhaseW-1:0] PhTurnRight  = 3'd4;
  localparam logic [PhaseW-1:0] PhNudgeLeft  = 3'd5;
  localparam logic [PhaseW-1:0] PhNudgeRight = 3'd6;
  localparam logic [PhaseW-1:0] PhRealign    = 3'd7;

  localparam logic [DirW-1:0] DirStop = 2'd0;
  localparam logic [DirW-1:0] DirFwd  = 2'd1;
  localparam logic [DirW-1:0] DirBack = 2'd2;

  typedef struct packed {
    logic [DistW-1:0]   front_safe_distance;
    logic [DistW-1:0]   safe_distance;
    logic [MarginW-1:0] wall_margin;
    logic [CompW-1:0]   nudge_angle;
    logic [TurnW-1:0]   turn_margin;
    logic [SpeedW-1:0]  full_speed;
  } cfg_t;

  typedef struct packed {
    logic [DistW-1:0]        front_distance;
    logic [DistW-1:0]        back_distance;
    logic [DistW-1:0]        right_distance;
    logic signed [HeadW-1:0] heading;
    logic                    restart;
  } item_t;

  typedef struct packed {
    logic              drive_valid;
    logic [DirW-1:0]   left_direction;
    logic [SpeedW-1:0] left_speed;
    logic [DirW-1:0]   right_direction;
    logic [SpeedW-1:0] right_speed;
    logic [PhaseW-1:0] phase;
    logic              recalibrate;
  } result_t;

endpackage

/* sv/wall_follow_drive_controller_top.sv */
// Right-wall-following drive controller.
// Input channel (in_valid_i/in_ready_o) carries one sensor tick: three range
// readings in cm, the unwrapped heading in 1/16 degree and a restart flag.
// Output channel (out_valid_o/out_ready_i) returns one result per tick: motor
// directions and speeds, drive_valid (0 while the motors hold), the phase
// entered on this tick and a recalibrate pulse that mirrors restart.
// The transfer edge captures the tick in an input register; the phase machine
// evaluates it combinationally and the result register loads the outcome once
// the result register is empty or being read by the receiver.
// Throughput is one tick per cycle unless the receiver stalls; the phase and
// target heading registers update in the same cycle the result register loads,
// so each tick sees the state left by the previous one.
// When the receiver stalls, the result register holds and the input register
// keeps one further tick; in_ready_o drops only when both are full.
// Reset clears both valid flags, sets the phase to wait-for-corner, the target
// heading to zero and the six configuration registers to their defaults.
// Write configuration through cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle;
// indexes 6 and 7 are ignored.
module wall_follow_drive_controller_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wfdc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [wfdc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [wfdc_pkg::DistW-1:0]         front_distance_i,
  input  logic [wfdc_pkg::DistW-1:0]         back_distance_i,
  input  logic [wfdc_pkg::DistW-1:0]         right_distance_i,
  input  logic signed [wfdc_pkg::HeadW-1:0]  heading_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               drive_valid_o,
  output logic [wfdc_pkg::DirW-1:0]          left_direction_o,
  output logic [wfdc_pkg::SpeedW-1:0]        left_speed_o,
  output logic [wfdc_pkg::DirW-1:0]          right_direction_o,
  output logic [wfdc_pkg::SpeedW-1:0]        right_speed_o,
  output logic [wfdc_pkg::PhaseW-1:0]        phase_o,
  output logic                               recalibrate_o
);
  import wfdc_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  result_t res, out_q;
  logic    in_valid_q, out_valid_q, adv, in_xfer;

  wfdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.front_distance <= front_distance_i;
      in_q.back_distance  <= back_distance_i;
      in_q.right_distance <= right_distance_i;
      in_q.heading        <= heading_i;
      in_q.restart        <= restart_i;
    end
  end

  wfdc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_valid_o     = out_q.drive_valid;
  assign left_direction_o  = out_q.left_direction;
  assign left_speed_o      = out_q.left_speed;
  assign right_direction_o = out_q.right_direction;
  assign right_speed_o     = out_q.right_speed;
  assign phase_o           = out_q.phase;
  assign recalibrate_o     = out_q.recalibrate;

endmodule

/* sv/wfdc_cfg.sv */
module wfdc_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wfdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wfdc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output wfdc_pkg::cfg_t            cfg_o
);
  import wfdc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_safe_distance <= DistW'(30);
      cfg_q.safe_distance       <= DistW'(20);
      cfg_q.wall_margin         <= MarginW'(5);
      cfg_q.nudge_angle         <= CompW'(160);
      cfg_q.turn_margin         <= TurnW'(80);
      cfg_q.full_speed          <= SpeedW'(200);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFrontSafe: cfg_q.front_safe_distance <= cfg_wdata_i[DistW-1:0];
        CfgSafe:      cfg_q.safe_distance       <= cfg_wdata_i[DistW-1:0];
        CfgWallMrg:   cfg_q.wall_margin         <= cfg_wdata_i[MarginW-1:0];
        CfgCompAng:   cfg_q.nudge_angle         <= cfg_wdata_i[CompW-1:0];
        CfgTurnMrg:   cfg_q.turn_margin         <= cfg_wdata_i[TurnW-1:0];
        CfgFullSpd:   cfg_q.full_speed          <= cfg_wdata_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/wfdc_core.sv */
module wfdc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  wfdc_pkg::cfg_t    cfg_i,
  input  wfdc_pkg::item_t   item_i,
  output wfdc_pkg::result_t res_o
);
  import wfdc_pkg::*;

  logic [PhaseW-1:0]         phase_q, phase_d, nxt;
  logic signed [TargetW-1:0] target_q, target_d;
  logic signed [TargetW-1:0] head_w, tgt_left, tgt_right, tgt_nl, tgt_nr;
  logic signed [DistW+1:0]   near_lim, right_s;
  logic [DistW:0]            far_lim;
  logic                      obs_front, obs_back, obs_right;
  logic [DirW-1:0]           ld, rd;
  logic                      valid;

  assign obs_front = item_i.front_distance <= cfg_i.front_safe_distance;
  assign obs_back  = item_i.back_distance  <= cfg_i.safe_distance;
  assign obs_right = item_i.right_distance <= cfg_i.safe_distance;

  assign near_lim = $signed({2'b00, cfg_i.safe_distance})
                  - $signed({4'b0000, cfg_i.wall_margin});
  assign right_s  = $signed({2'b00, item_i.right_distance});
  assign far_lim  = {1'b0, cfg_i.safe_distance} + {3'b000, cfg_i.wall_margin};

  assign head_w    = {item_i.heading[HeadW-1], item_i.heading};
  assign tgt_left  = head_w + QuarterTurn - $signed({10'b0, cfg_i.turn_margin});
  assign tgt_right = head_w - QuarterTurn + $signed({10'b0, cfg_i.turn_margin});
  assign tgt_nl    = head_w + $signed({9'b0, cfg_i.nudge_angle});
  assign tgt_nr    = head_w - $signed({9'b0, cfg_i.nudge_angle});

  always_comb begin
    nxt      = phase_q;
    target_d = target_q;
    unique case (phase_q)
      PhWaitCorner: if (obs_right && obs_back) nxt = PhWaitClear;
      PhWaitClear:  if (!obs_front) nxt = PhFollow;
      PhFollow: begin
        if (obs_front) begin
          nxt      = PhTurnLeft;
          target_d = tgt_left;
        end else if (!obs_right) begin
          nxt      = PhTurnRight;
          target_d = tgt_right;
        end else if (right_s < near_lim) begin
          nxt      = PhNudgeLeft;
          target_d = tgt_nl;
        end else if ({1'b0, item_i.right_distance} > far_lim) begin
          nxt      = PhNudgeRight;
          target_d = tgt_nr;
        end
      end
      PhTurnLeft:   if (target_q <= head_w) nxt = PhRealign;
      PhTurnRight:  if (target_q >= head_w) nxt = PhRealign;
      PhNudgeLeft:  if (target_q <= head_w) nxt = PhFollow;
      PhNudgeRight: if (target_q >= head_w) nxt = PhFollow;
      default:      if (obs_right) nxt = PhFollow;
    endcase
    phase_d = item_i.restart ? PhWaitCorner : nxt;
  end

  always_comb begin
    ld    = DirStop;
    rd    = DirStop;
    valid = 1'b1;
    unique case (phase_d)
      PhFollow, PhRealign: begin
        ld = DirFwd;
        rd = DirBack;
      end
      PhTurnLeft: begin
        ld = DirBack;
        rd = DirBack;
      end
      PhTurnRight: begin
        ld = DirFwd;
        rd = DirFwd;
      end
      PhNudgeLeft:  rd = DirBack;
      PhNudgeRight: ld = DirFwd;
      default:      valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhWaitCorner;
      target_q <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      target_q <= target_d;
    end
  end

  assign res_o.drive_valid     = valid;
  assign res_o.left_direction  = ld;
  assign res_o.left_speed      = (ld == DirStop) ? '0 : cfg_i.full_speed;
  assign res_o.right_direction = rd;
  assign res_o.right_speed     = (rd == DirStop) ? '0 : cfg_i.full_speed;
  assign res_o.phase           = phase_d;
  assign res_o.recalibrate     = item_i.restart;

endmodule
